// ===== sv/edrs_pkg.sv =====
// ----------------------------------------------------------------------------
// edrs_pkg: shared types and constants of the elevator disk request scheduler
// Widths, command and status codes, the queued command record and the
// request clamping helpers.
// ----------------------------------------------------------------------------
package edrs_pkg;

  localparam int unsigned SLOTS   = 8;
  localparam int unsigned TRACKS  = 100;
  localparam int unsigned SECTORS = 8;

  localparam int unsigned SLOT_W = 3;
  localparam int unsigned TRK_W  = 7;
  localparam int unsigned SEC_W  = 3;
  localparam int unsigned KEY_W  = TRK_W + SEC_W;

  typedef enum logic {
    OP_SUBMIT = 1'b0,
    OP_GRANT  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_ACCEPTED = 2'd0,
    ST_BUSY     = 2'd1,
    ST_GRANTED  = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    BK_IDLE = 3'b001,
    BK_SCAN = 3'b010,
    BK_DONE = 3'b100
  } back_state_e;

  typedef struct packed {
    op_e               op;
    logic [SLOT_W-1:0] slot;
    logic [TRK_W-1:0]  track;
    logic [SEC_W-1:0]  sector;
    logic              wr;
  } cmd_t;

  typedef struct packed {
    status_e           status;
    logic [SLOT_W-1:0] slot;
    logic [TRK_W-1:0]  track;
    logic [SEC_W-1:0]  sector;
    logic              wr;
    logic              sweep_up;
  } rsp_t;

  function automatic logic [TRK_W-1:0] sat_track(input logic [TRK_W-1:0] t);
    logic [TRK_W-1:0] r;
    r = t;
    if (32'(t) >= TRACKS) r = TRK_W'(TRACKS - 1);
    return r;
  endfunction

  function automatic logic [SEC_W-1:0] sat_sector(input logic [SEC_W-1:0] s);
    logic [SEC_W-1:0] r;
    r = s;
    if (32'(s) >= SECTORS) r = SEC_W'(SECTORS - 1);
    return r;
  endfunction

endpackage

// ===== sv/edrs_req_if.sv =====
// ----------------------------------------------------------------------------
// edrs_req_if: request channel
// Valid/ready channel carrying one submit or grant command.
// ----------------------------------------------------------------------------
interface edrs_req_if;
  import edrs_pkg::*;

  logic              valid;
  logic              ready;
  logic              command;
  logic [SLOT_W-1:0] slot;
  logic [TRK_W-1:0]  track;
  logic [SEC_W-1:0]  sector;
  logic              is_write;

  modport source (output valid, command, slot, track, sector, is_write, input ready);
  modport sink   (input valid, command, slot, track, sector, is_write, output ready);
endinterface

// ===== sv/edrs_rsp_if.sv =====
// ----------------------------------------------------------------------------
// edrs_rsp_if: result channel
// Valid/ready channel carrying one status and grant record per command.
// ----------------------------------------------------------------------------
interface edrs_rsp_if;
  import edrs_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [SLOT_W-1:0] grant_slot;
  logic [TRK_W-1:0]  grant_track;
  logic [SEC_W-1:0]  grant_sector;
  logic              grant_write;
  logic              sweep_up;

  modport source (output valid, status, grant_slot, grant_track, grant_sector,
                  grant_write, sweep_up, input ready);
  modport sink   (input valid, status, grant_slot, grant_track, grant_sector,
                  grant_write, sweep_up, output ready);
endinterface

// ===== sv/edrs_front.sv =====
// ----------------------------------------------------------------------------
// edrs_front: command intake
// Takes request transfers, decodes the command, clamps track and sector and
// holds the classified command in a register for the queue.
// ----------------------------------------------------------------------------
module edrs_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  edrs_req_if.sink       req_i,
  output edrs_pkg::cmd_t cmd_o,
  output logic           cmd_valid_o,
  input  logic           cmd_ready_i
);
  import edrs_pkg::*;

  logic valid_q, valid_d;
  cmd_t cmd_q, cmd_d;
  logic take;

  assign req_i.ready = !valid_q || cmd_ready_i;
  assign take        = req_i.valid && req_i.ready;

  always_comb begin
    cmd_d    = cmd_q;
    valid_d  = valid_q;
    if (take) begin
      valid_d    = 1'b1;
      cmd_d.op   = op_e'(req_i.command);
      // grants ignore the request fields
      if (op_e'(req_i.command) == OP_SUBMIT) begin
        cmd_d.slot   = req_i.slot;
        cmd_d.track  = sat_track(req_i.track);
        cmd_d.sector = sat_sector(req_i.sector);
        cmd_d.wr     = req_i.is_write;
      end else begin
        cmd_d.slot   = '0;
        cmd_d.track  = '0;
        cmd_d.sector = '0;
        cmd_d.wr     = 1'b0;
      end
    end else if (cmd_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

  assign cmd_o       = cmd_q;
  assign cmd_valid_o = valid_q;

endmodule

// ===== sv/edrs_queue.sv =====
// ----------------------------------------------------------------------------
// edrs_queue: command queue
// Two-entry queue between the intake and the scheduler core.
// ----------------------------------------------------------------------------
module edrs_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  edrs_pkg::cmd_t push_cmd_i,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  output edrs_pkg::cmd_t pop_cmd_o,
  output logic           pop_valid_o,
  input  logic           pop_ready_i
);
  import edrs_pkg::*;

  cmd_t       mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] count_q;
  logic       push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_cmd_o    = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push) wptr_q <= !wptr_q;
      if (pop)  rptr_q <= !rptr_q;
      if (push && !pop)      count_q <= count_q + 2'd1;
      else if (pop && !push) count_q <= count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wptr_q] <= push_cmd_i;
  end

endmodule

// ===== sv/edrs_back.sv =====
// ----------------------------------------------------------------------------
// edrs_back: scheduler core
// Holds the per-slot requests, runs the SCAN search one slot per cycle and
// registers the result for the output channel.
// ----------------------------------------------------------------------------
module edrs_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  edrs_pkg::cmd_t cmd_i,
  input  logic           cmd_valid_i,
  output logic           cmd_ready_o,
  edrs_rsp_if.source     rsp_o
);
  import edrs_pkg::*;

  back_state_e state_q, state_d;

  logic [SLOTS-1:0]  pend_q;
  logic [TRK_W-1:0]  trk_q [SLOTS];
  logic [SEC_W-1:0]  sec_q [SLOTS];
  logic              wr_q  [SLOTS];
  logic [TRK_W-1:0]  head_trk_q;
  logic [SEC_W-1:0]  head_sec_q;
  logic              up_q;

  logic [SLOT_W-1:0] idx_q;
  logic              upf_q, dnf_q;
  logic [SLOT_W-1:0] up_idx_q, dn_idx_q;
  logic [KEY_W-1:0]  up_key_q, dn_key_q;

  logic              out_valid_q;
  rsp_t              out_q;

  logic              pop, is_submit, busy;
  logic [KEY_W-1:0]  head_key, cur_key;
  logic              cand_up, cand_dn, last_slot;
  logic              have_pick, flip;
  logic [SLOT_W-1:0] pick_idx;

  assign cmd_ready_o = (state_q == BK_IDLE) && !out_valid_q;
  assign pop         = cmd_valid_i && cmd_ready_o;
  assign is_submit   = (cmd_i.op == OP_SUBMIT);
  assign busy        = pend_q[cmd_i.slot];

  assign head_key  = {head_trk_q, head_sec_q};
  assign cur_key   = {trk_q[idx_q], sec_q[idx_q]};
  assign last_slot = (idx_q == SLOT_W'(SLOTS - 1));

  // strict compares keep the lowest slot on equal keys
  assign cand_up = pend_q[idx_q] && (cur_key >= head_key) &&
                   (!upf_q || cur_key < up_key_q);
  assign cand_dn = pend_q[idx_q] && (cur_key < head_key) &&
                   (!dnf_q || cur_key > dn_key_q);

  // keep the current sweep if it has a candidate, else reverse
  always_comb begin
    have_pick = 1'b0;
    flip      = 1'b0;
    pick_idx  = up_idx_q;
    if (up_q) begin
      if (upf_q) begin
        have_pick = 1'b1;
      end else if (dnf_q) begin
        have_pick = 1'b1;
        flip      = 1'b1;
        pick_idx  = dn_idx_q;
      end
    end else begin
      if (dnf_q) begin
        have_pick = 1'b1;
        pick_idx  = dn_idx_q;
      end else if (upf_q) begin
        have_pick = 1'b1;
        flip      = 1'b1;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: if (pop && !is_submit) state_d = BK_SCAN;
      BK_SCAN: if (last_slot) state_d = BK_DONE;
      BK_DONE: state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      pend_q      <= '0;
      head_trk_q  <= '0;
      head_sec_q  <= '0;
      up_q        <= 1'b1;
      idx_q       <= '0;
      upf_q       <= 1'b0;
      dnf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_valid_q && rsp_o.ready) out_valid_q <= 1'b0;
      case (state_q)
        BK_IDLE: begin
          if (pop) begin
            if (is_submit) begin
              out_valid_q <= 1'b1;
              if (!busy) pend_q[cmd_i.slot] <= 1'b1;
            end else begin
              idx_q <= '0;
              upf_q <= 1'b0;
              dnf_q <= 1'b0;
            end
          end
        end
        BK_SCAN: begin
          idx_q <= idx_q + SLOT_W'(1);
          if (cand_up) upf_q <= 1'b1;
          if (cand_dn) dnf_q <= 1'b1;
        end
        BK_DONE: begin
          out_valid_q <= 1'b1;
          if (have_pick) begin
            pend_q[pick_idx] <= 1'b0;
            head_trk_q       <= trk_q[pick_idx];
            head_sec_q       <= sec_q[pick_idx];
            up_q             <= up_q ^ flip;
          end
        end
        default: ;
      endcase
    end
  end

  // request store, best-candidate payload and result record
  always_ff @(posedge clk_i) begin
    if (state_q == BK_IDLE && pop && is_submit && !busy) begin
      trk_q[cmd_i.slot] <= cmd_i.track;
      sec_q[cmd_i.slot] <= cmd_i.sector;
      wr_q[cmd_i.slot]  <= cmd_i.wr;
    end
    if (state_q == BK_SCAN) begin
      if (cand_up) begin
        up_idx_q <= idx_q;
        up_key_q <= cur_key;
      end
      if (cand_dn) begin
        dn_idx_q <= idx_q;
        dn_key_q <= cur_key;
      end
    end
    if (state_q == BK_IDLE && pop && is_submit) begin
      out_q.status   <= busy ? ST_BUSY : ST_ACCEPTED;
      out_q.slot     <= '0;
      out_q.track    <= '0;
      out_q.sector   <= '0;
      out_q.wr       <= 1'b0;
      out_q.sweep_up <= up_q;
    end else if (state_q == BK_DONE) begin
      out_q.sweep_up <= up_q ^ flip;
      if (have_pick) begin
        out_q.status <= ST_GRANTED;
        out_q.slot   <= pick_idx;
        out_q.track  <= trk_q[pick_idx];
        out_q.sector <= sec_q[pick_idx];
        out_q.wr     <= wr_q[pick_idx];
      end else begin
        out_q.status <= ST_EMPTY;
        out_q.slot   <= '0;
        out_q.track  <= '0;
        out_q.sector <= '0;
        out_q.wr     <= 1'b0;
      end
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = out_q.status;
  assign rsp_o.grant_slot   = out_q.slot;
  assign rsp_o.grant_track  = out_q.track;
  assign rsp_o.grant_sector = out_q.sector;
  assign rsp_o.grant_write  = out_q.wr;
  assign rsp_o.sweep_up     = out_q.sweep_up;

endmodule

// ===== sv/elevator_disk_request_scheduler.sv =====
// ----------------------------------------------------------------------------
// elevator_disk_request_scheduler: SCAN disk request scheduler
// A submit stores one request per slot; a grant hands out the next pending
// request in elevator order from the head. Every command returns one result.
// Commands pass an intake register and a two-entry queue before the core, so
// new commands are taken while a result waits on the output. A submit is
// stored and answered from the idle state; a grant scans all slots one per
// cycle, then picks a request, moves the head and registers the result.
// Track values above 99 are stored as 99.
// ----------------------------------------------------------------------------
module elevator_disk_request_scheduler (
  input  logic       clk_i,
  input  logic       rst_ni,
  edrs_req_if.sink   req_i,
  edrs_rsp_if.source rsp_o
);
  import edrs_pkg::*;

  cmd_t front_cmd, queue_cmd;
  logic front_valid, front_ready;
  logic queue_valid, queue_ready;

  edrs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_o       (front_cmd),
    .cmd_valid_o (front_valid),
    .cmd_ready_i (front_ready)
  );

  edrs_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_cmd_i   (front_cmd),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .pop_cmd_o    (queue_cmd),
    .pop_valid_o  (queue_valid),
    .pop_ready_i  (queue_ready)
  );

  edrs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (queue_cmd),
    .cmd_valid_i (queue_valid),
    .cmd_ready_o (queue_ready),
    .rsp_o       (rsp_o)
  );

endmodule
